// ===== hw/rtl/macs_pkg.sv =====
package macs_pkg;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  localparam logic [1:0] REG_RUN   = 2'd0;
  localparam logic [1:0] REG_SHORT = 2'd1;
  localparam logic [1:0] REG_LONG  = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  localparam int MID_W  = 33;
  localparam int WIN_W  = 7;
  localparam int LIM_W  = 24;
  localparam int ONE_Q  = 65536;
  localparam int FAC_W  = 25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_RD,
    ST_ACC,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_CMP_BUY,
    ST_MUL_D,
    ST_CMP_SELL,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/moving_average_crossover_signal.sv =====
// Channel   Direction  Handshake        Payload
// in        input      in_valid/stall   symbol_id, bid_price, ask_price
// out       output     out_valid/stall  trade_signal
// cfg       input      cfg_valid/ready  cfg_index, cfg_data
//
// A beat is taken only when the block is idle: every sample of the long and
// then the short window passes a read state and an accumulate state on the
// history memory, then a single shared 47x25 multiplier forms up to four
// products, one per cycle; the fourth only when a sell test is needed.
// Stopped or out-of-range beats, too few samples and a zero long sum skip
// the remaining steps.
// Reset (rst, sync) clears fill counts, write slots, state, output flag and
// config registers; history memory is not cleared, only written entries are read.
// in_stall is high while busy; the result sits in an output register until
// taken, and the next beat is accepted in that same cycle it leaves.
module moving_average_crossover_signal
  import macs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 100,
  parameter int SYMBOL_COUNT  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        symbol_id,
  input  logic [31:0]       bid_price,
  input  logic [31:0]       ask_price,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        trade_signal,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int SYM_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ADDR_W = $clog2(SYMBOL_COUNT * HISTORY_DEPTH);
  localparam int SUM_W  = MID_W + WIN_W;
  localparam int PRD_W  = SUM_W + WIN_W;
  localparam int WIDE_W = PRD_W + FAC_W;

  logic             run_enable;
  logic [WIN_W-1:0] short_window, long_window;
  logic [LIM_W-1:0] momentum_limit;

  logic [MID_W-1:0] mem [SYMBOL_COUNT*HISTORY_DEPTH];
  logic [MID_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic [CNT_W-1:0]  fill_count [SYMBOL_COUNT];
  logic [SLOT_W-1:0] write_slot [SYMBOL_COUNT];

  state_t state, state_next;
  logic [SYM_W-1:0]  sym;
  logic [MID_W-1:0]  mid;
  logic [SLOT_W-1:0] pos;
  logic [WIN_W-1:0]  left;
  logic              pass;      // 0 long sum, 1 short sum
  logic [SUM_W-1:0]  acc, lsum;
  logic [WIDE_W-1:0] prod, lhs, rhs;
  logic [1:0]        sig;
  logic              out_full;

  logic in_fire, out_fire, sym_ok;
  logic [CNT_W-1:0] cnt_now;
  logic [SLOT_W-1:0] pos_dec;

  assign in_stall  = (state != ST_IDLE) || (out_full && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_full;
  assign out_fire  = out_full && !out_stall;
  assign cfg_ready = 1'b1;
  assign trade_signal = sig;
  assign sym_ok    = 32'(symbol_id) < 32'(SYMBOL_COUNT);
  assign cnt_now   = fill_count[sym];
  assign pos_dec   = (pos == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : pos - 1'b1;
  assign rd_addr   = ADDR_W'(sym) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(pos_dec);

  // shared multiplier: both operands selected by state
  logic [PRD_W-1:0] mul_a;
  logic [FAC_W-1:0] mul_b;
  logic [WIDE_W-1:0] mul_out;
  always_comb begin
    mul_a = PRD_W'(acc);
    mul_b = FAC_W'(long_window);
    case (state)
      ST_MUL_A: begin mul_a = PRD_W'(acc);  mul_b = FAC_W'(long_window);  end
      ST_MUL_B: begin mul_a = PRD_W'(lsum); mul_b = FAC_W'(short_window); end
      ST_MUL_C: begin mul_a = prod[PRD_W-1:0];
                      mul_b = FAC_W'(ONE_Q) + FAC_W'(momentum_limit); end
      ST_MUL_D: begin mul_a = prod[PRD_W-1:0];
                      mul_b = FAC_W'(ONE_Q) - FAC_W'(momentum_limit); end
      default: ;
    endcase
  end
  assign mul_out = WIDE_W'(mul_a) * WIDE_W'(mul_b);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire) state_next = (run_enable && sym_ok) ? ST_WRITE : ST_OUT;
      ST_WRITE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (CMP_W'(cnt_now) < CMP_W'(long_window) || short_window == '0 ||
            CMP_W'(short_window) > CMP_W'(cnt_now) || long_window == '0)
          state_next = ST_OUT;
        else state_next = ST_RD;
      end
      ST_RD:    state_next = ST_ACC;
      ST_ACC: begin
        if (left != WIN_W'(1)) state_next = ST_RD;
        else if (!pass) state_next = (acc + SUM_W'(rd_data) == '0) ? ST_OUT : ST_RD;
        else state_next = ST_MUL_A;
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_MUL_C;
      ST_MUL_C: state_next = ST_CMP_BUY;
      ST_CMP_BUY: state_next = (lhs > prod) ? ST_OUT :
                               (momentum_limit < LIM_W'(ONE_Q)) ? ST_MUL_D : ST_OUT;
      ST_MUL_D: state_next = ST_CMP_SELL;
      ST_CMP_SELL: state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE)
      mem[ADDR_W'(sym) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(write_slot[sym])] <= mid;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
      run_enable <= 1'b0;
      short_window <= WIN_W'(1);
      long_window <= WIN_W'(1);
      momentum_limit <= '0;
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        fill_count[i] <= '0;
        write_slot[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_RUN:   run_enable <= cfg_data[0];
          REG_SHORT: short_window <= cfg_data[WIN_W-1:0];
          REG_LONG:  long_window <= cfg_data[WIN_W-1:0];
          REG_LIMIT: momentum_limit <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_fire) out_full <= 1'b0;
      if (state == ST_OUT) out_full <= 1'b1;
      if (state == ST_WRITE) begin
        write_slot[sym] <= (write_slot[sym] == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                           : write_slot[sym] + 1'b1;
        if (fill_count[sym] < CNT_W'(HISTORY_DEPTH))
          fill_count[sym] <= fill_count[sym] + 1'b1;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_fire) begin
        sym <= SYM_W'(symbol_id);
        mid <= {1'b0, bid_price} + {1'b0, ask_price};
        sig <= SIG_NONE;
      end
      ST_WRITE: ;
      ST_CHECK: begin
        pos  <= write_slot[sym];
        left <= long_window;
        pass <= 1'b0;
        acc  <= '0;
      end
      ST_RD: pos <= pos_dec;
      ST_ACC: begin
        if (left != WIN_W'(1)) begin
          acc  <= acc + SUM_W'(rd_data);
          left <= left - 1'b1;
        end else if (!pass) begin
          lsum <= acc + SUM_W'(rd_data);
          acc  <= '0;
          pass <= 1'b1;
          left <= short_window;
          pos  <= write_slot[sym];
        end else acc <= acc + SUM_W'(rd_data);
      end
      ST_MUL_A: lhs  <= mul_out << 16;
      ST_MUL_B: prod <= mul_out;
      ST_MUL_C: begin
        rhs  <= prod;
        prod <= mul_out;
      end
      ST_CMP_BUY: begin
        if (lhs > prod) sig <= SIG_BUY;
        prod <= rhs;
      end
      ST_MUL_D: prod <= mul_out;
      ST_CMP_SELL: if (lhs < prod) sig <= SIG_SELL;
      default: ;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(trade_signal)))
    else $error("result lost");
  a_sig_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trade_signal != 2'd3)) else $error("bad signal code");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !out_full) else $error("result register overwritten");

endmodule

// ===== bench/crossover_checker.sv =====
module crossover_checker
  import macs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  symbol_id,
  input  logic [31:0] bid_price,
  input  logic [31:0] ask_price,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  trade_signal,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          beats_out,
  output int          buys,
  output int          sells
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 100;
  localparam int SYMS  = 3;
  localparam int FIFO_N = 16;

  logic [MID_W-1:0] mids [SYMS][DEPTH];
  int               filled [SYMS];
  int               slot [SYMS];
  logic             running;
  logic [WIN_W-1:0] short_n, long_n;
  logic [LIM_W-1:0] limit_q;
  logic [1:0]       sig_fifo [FIFO_N];
  int               head, tail, used;

  function automatic logic [63:0] window_sum(int s, int n);
    logic [63:0] acc;
    int p;
    acc = 0;
    p = slot[s];
    for (int i = 0; i < n; i++) begin
      p = (p == 0) ? DEPTH - 1 : p - 1;
      acc += mids[s][p];
    end
    return acc;
  endfunction

  function automatic logic [1:0] crossover(int s);
    logic [63:0]  ssum, lsum, a, b;
    logic [127:0] lhs, rhs;
    if (filled[s] < long_n) return SIG_NONE;
    if (short_n == 0 || short_n > filled[s]) return SIG_NONE;
    lsum = window_sum(s, long_n);
    if (lsum == 0) return SIG_NONE;
    ssum = window_sum(s, short_n);
    a = ssum * 64'(long_n);
    b = lsum * 64'(short_n);
    lhs = {64'd0, a} << 16;
    rhs = 128'(b) * (128'd65536 + 128'(limit_q));
    if (lhs > rhs) return SIG_BUY;
    if (limit_q < 24'(ONE_Q)) begin
      rhs = 128'(b) * (128'd65536 - 128'(limit_q));
      if (lhs < rhs) return SIG_SELL;
    end
    return SIG_NONE;
  endfunction

  always @(posedge clk) begin
    logic [1:0] want;
    if (rst) begin
      for (int s = 0; s < SYMS; s++) begin
        filled[s] = 0;
        slot[s] = 0;
      end
      running = 0; short_n = 1; long_n = 1; limit_q = 0;
      head = 0; tail = 0; used = 0;
      fail_count <= 0; beats_out <= 0; buys <= 0; sells <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (used == 0) begin
          $error("unexpected result beat trade_signal=%0d", trade_signal);
          fail_count <= fail_count + 1;
        end else begin
          want = sig_fifo[head];
          head = (head + 1) % FIFO_N;
          used--;
          if (want == SIG_BUY) buys <= buys + 1;
          if (want == SIG_SELL) sells <= sells + 1;
          if (trade_signal !== want) begin
            $error("trade_signal expected %0d actual %0d", want, trade_signal);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = SIG_NONE;
        if (running && symbol_id < SYMS) begin
          mids[symbol_id][slot[symbol_id]] = 33'(bid_price) + 33'(ask_price);
          slot[symbol_id] = (slot[symbol_id] + 1 >= DEPTH) ? 0 : slot[symbol_id] + 1;
          if (filled[symbol_id] < DEPTH) filled[symbol_id]++;
          want = crossover(symbol_id);
        end
        sig_fifo[tail] = want;
        tail = (tail + 1) % FIFO_N;
        used++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RUN:   running = cfg_data[0];
          REG_SHORT: short_n = cfg_data[WIN_W-1:0];
          REG_LONG:  long_n  = cfg_data[WIN_W-1:0];
          REG_LIMIT: limit_q = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= used;
  end
endmodule

// ===== bench/tb.sv =====
module tb;
  import macs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic [1:0]  symbol_id = 0, cfg_index = 0;
  logic [31:0] bid_price = 0, ask_price = 0, cfg_data = 0;
  logic        in_stall, out_valid, cfg_ready;
  logic [1:0]  trade_signal;
  int          fail_count, pending, beats_out, buys, sells;
  int          idle_cycles = 0;
  int          beats_in = 0;
  bit          hold_off = 0;   // long receiver hold-off request
  bit          holding = 0;

  localparam int IDLE_LIMIT = 20000;

  moving_average_crossover_signal dut (.*);

  crossover_checker chk (.*);

  initial forever #1 clk = ~clk;

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (!rst && !holding)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // short gaps mostly, an occasional long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // receiver stall, in its own process
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        holding = 1;
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
        holding = 0;
      end
      n = gap_len();
      out_stall <= (n != 0);
      repeat (n > 0 ? n : 1) @(negedge clk);
      out_stall <= 0;
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_strategy(input int s_n, input int l_n, input int lim);
    write_reg(REG_SHORT, s_n);
    write_reg(REG_LONG, l_n);
    write_reg(REG_LIMIT, lim);
  endtask

  // wait until the block has drained, then let the bench idle
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // one market-data beat; optional gap before it
  task automatic send_tick(input logic [1:0] sym, input logic [31:0] bid,
                           input logic [31:0] ask, input bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    repeat (n) @(negedge clk);
    in_valid  = 1;
    symbol_id = sym;
    bid_price = bid;
    ask_price = ask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // random tick near a per-symbol drifting base price
  logic [31:0] base [3];
  task automatic trend_tick(input bit gaps);
    logic [1:0] s;
    int step, spread;
    s = 2'($urandom_range(0, 2));
    step = $urandom_range(0, 2000) - 1000;
    base[s] = base[s] + step;
    spread = $urandom_range(0, 50);
    send_tick(s, base[s], base[s] + spread, gaps);
  endtask

  initial begin
    int s_n, l_n, lim;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // stopped: no history update
    send_tick(2'd0, 32'd100, 32'd200, 1'b0);
    drain();
    write_reg(REG_RUN, 32'd1);
    set_strategy(1, 1, 0);
    // extremes of the price fields and out-of-range symbol
    send_tick(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_tick(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_tick(2'd1, 32'h0, 32'h0, 1'b0);       // zero long sum
    send_tick(2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    drain();
    set_strategy(2, 3, 32'h0000_1000);     // too few samples first
    send_tick(2'd1, 32'd0, 32'd0, 1'b0);
    send_tick(2'd1, 32'd1000, 32'd1000, 1'b0);
    send_tick(2'd1, 32'd3000, 32'd3000, 1'b0); // buy
    send_tick(2'd1, 32'd10, 32'd10, 1'b0);     // buy again
    send_tick(2'd1, 32'd10, 32'd10, 1'b0);
    drain();
    set_strategy(5, 2, 32'h00FF_FFFF);     // short window longer than long
    for (int i = 0; i < 6; i++) send_tick(2'd2, $urandom, $urandom, 1'b0);
    drain();
    set_strategy(0, 1, 32'h0001_0000);     // zero short window
    send_tick(2'd2, 32'd5, 32'd7, 1'b0);
    drain();
    write_reg(REG_RUN, 32'd0);
    send_tick(2'd2, 32'd5, 32'd7, 1'b0);
    drain();
    write_reg(REG_RUN, 32'd1);
    set_strategy(100, 100, 32'h0000_0100);
    for (int s = 0; s < 3; s++) base[s] = 32'h4000_0000 + $urandom_range(0, 1 << 20);

    // random phases, mostly small windows
    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 5 == 4) begin
        s_n = $urandom_range(1, 100); l_n = $urandom_range(1, 100);
      end else begin
        s_n = $urandom_range(1, 8); l_n = $urandom_range(1, 12);
      end
      lim = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
      if (ph == 2) write_reg(REG_RUN, 32'd0);
      if (ph == 3) write_reg(REG_RUN, 32'd1);
      set_strategy(s_n, l_n, lim);
      if (ph == 6) hold_off = 1;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_tick(2'($urandom_range(0, 3)), $urandom, $urandom, 1'b1);
        else
          trend_tick(ph != 6);
      end
      drain();   // sender pauses until all results have come
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("summary: %0d ticks in, %0d signals out (%0d buy, %0d sell)",
             beats_in, beats_out, buys, sells);
    $display("covered stopped, bad symbol, short windows, full rings and extreme limits");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
